// ----- hdl/pipe_domain_position_projector_top_macros.svh -----
// Assertion macros used by the projector top module.
`ifndef PIPE_DOMAIN_POSITION_PROJECTOR_TOP_MACROS_SVH
`define PIPE_DOMAIN_POSITION_PROJECTOR_TOP_MACROS_SVH
`define PDP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hdl/pdp_pkg.sv -----
package pdp_pkg;
    localparam int CoordWidth = 32;
    localparam int RegWidth = 28;
    localparam int FracBits = 16;
    localparam int LenWidth = 36;
    localparam int QuotWidth = 36;

    typedef enum logic [1:0] {
        REGION_LOWER = 2'd0,
        REGION_TOP = 2'd1,
        REGION_LEGS = 2'd2
    } region_t;

    localparam logic [0:0] ADDR_RADIUS = 1'b0;
    localparam logic [0:0] ADDR_LEG_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [CoordWidth-1:0] pos_x;
        logic signed [CoordWidth-1:0] pos_y;
    } pdp_in_t;

    typedef struct packed {
        logic signed [CoordWidth-1:0] new_x;
        logic signed [CoordWidth-1:0] new_y;
        logic [1:0] region_code;
        logic was_moved;
        logic at_centre_flag;
    } pdp_out_t;
endpackage

// ----- hdl/pdp_regs.sv -----
module pdp_regs
    import pdp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    output logic [RegWidth-1:0] radius,
    output logic [RegWidth-1:0] leg_height
);
    logic [RegWidth-1:0] radius_reg;
    logic [RegWidth-1:0] height_reg;
    logic wr_en;
    logic known;

    assign pready = 1'b1;
    assign known = (paddr[1:0] == 2'b00);
    assign wr_en = psel && penable && pwrite && known;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RegWidth'(131072);
            height_reg <= RegWidth'(196608);
        end
        else if (wr_en)
        begin
            if (paddr[2:2] == ADDR_RADIUS)
                radius_reg <= pwdata[RegWidth-1:0];
            else
                height_reg <= pwdata[RegWidth-1:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (known && paddr[2:2] == ADDR_RADIUS)
            prdata = {4'd0, radius_reg};
        else if (known && paddr[2:2] == ADDR_LEG_HEIGHT)
            prdata = {4'd0, height_reg};
    end

    assign radius = radius_reg;
    assign leg_height = height_reg;
endmodule

// ----- hdl/pdp_isqrt.sv -----
// Pipelined square root, one result bit per stage.
module pdp_isqrt
    import pdp_pkg::*;
#(
    parameter int InWidth = 72,
    parameter int OutWidth = 36,
    parameter int TagWidth = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic [InWidth-1:0] in_value,
    input  logic [TagWidth-1:0] in_tag,
    output logic out_valid,
    output logic [OutWidth-1:0] out_root,
    output logic [InWidth-1:0] out_value,
    output logic [TagWidth-1:0] out_tag
);
    logic [OutWidth:0] vld_reg;
    logic [OutWidth-1:0] root_reg [0:OutWidth];
    logic [InWidth-1:0] rem_reg [0:OutWidth];
    logic [OutWidth:0][InWidth-1:0] val_reg;
    logic [OutWidth:0][TagWidth-1:0] tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= OutWidth; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg[0] <= '0;
        rem_reg[0] <= in_value;
        val_reg[0] <= in_value;
        tag_reg[0] <= in_tag;
        for (int i = 1; i <= OutWidth; i++)
        begin
            val_reg[i] <= val_reg[i-1];
            tag_reg[i] <= tag_reg[i-1];
        end
    end

    genvar g;
    generate
        for (g = 1; g <= OutWidth; g++)
        begin : g_step
            localparam int B = OutWidth - g;
            logic [InWidth+1:0] trial;
            logic [InWidth+1:0] root_w;
            assign root_w = (InWidth+2)'(root_reg[g-1]);
            assign trial = ((root_w << 1) | ((InWidth+2)'(1) << B)) << B;
            always_ff @(posedge clk)
            begin
                if ((InWidth+2)'(rem_reg[g-1]) >= trial)
                begin
                    rem_reg[g] <= rem_reg[g-1] - trial[InWidth-1:0];
                    root_reg[g] <= root_reg[g-1] | (OutWidth'(1) << B);
                end
                else
                begin
                    rem_reg[g] <= rem_reg[g-1];
                    root_reg[g] <= root_reg[g-1];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[OutWidth];
    assign out_root = root_reg[OutWidth];
    assign out_value = val_reg[OutWidth];
    assign out_tag = tag_reg[OutWidth];
endmodule

// ----- hdl/pdp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module pdp_div
    import pdp_pkg::*;
#(
    parameter int NumWidth = 66,
    parameter int DenWidth = 36,
    parameter int TagWidth = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic [NumWidth-1:0] in_num,
    input  logic [DenWidth-1:0] in_den,
    input  logic [TagWidth-1:0] in_tag,
    output logic out_valid,
    output logic [NumWidth-1:0] out_quot,
    output logic [TagWidth-1:0] out_tag
);
    logic [NumWidth:0] vld_reg;
    logic [NumWidth-1:0] q_reg [0:NumWidth];
    logic [DenWidth:0] rem_reg [0:NumWidth];
    logic [DenWidth-1:0] den_reg [0:NumWidth];
    logic [TagWidth-1:0] tag_reg [0:NumWidth];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= NumWidth; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= in_num;
        rem_reg[0] <= '0;
        den_reg[0] <= in_den;
        tag_reg[0] <= in_tag;
    end

    genvar g;
    generate
        for (g = 1; g <= NumWidth; g++)
        begin : g_step
            logic [DenWidth+1:0] shifted;
            assign shifted = {rem_reg[g-1], q_reg[g-1][NumWidth-1]};
            always_ff @(posedge clk)
            begin
                den_reg[g] <= den_reg[g-1];
                tag_reg[g] <= tag_reg[g-1];
                if (shifted >= (DenWidth+2)'(den_reg[g-1]))
                begin
                    rem_reg[g] <= (DenWidth+1)'(shifted - (DenWidth+2)'(den_reg[g-1]));
                    q_reg[g] <= {q_reg[g-1][NumWidth-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g] <= shifted[DenWidth:0];
                    q_reg[g] <= {q_reg[g-1][NumWidth-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NumWidth];
    assign out_quot = q_reg[NumWidth];
    assign out_tag = tag_reg[NumWidth];
endmodule

// ----- hdl/pipe_domain_position_projector_top.sv -----
// One transaction enters per clock when start is high and busy is low; busy is always low.
// Each result is on out_valid for exactly one cycle. Its transaction passes three classify
// stages, a 37-stage square-root pipeline, a numerator stage, two 67-stage divider
// pipelines that run side by side for x and y, and two output stages.
// The receiver cannot stall; results must be taken when out_valid is high.
// Write registers only while no transaction is in flight; the block does not enforce it.
`include "pipe_domain_position_projector_top_macros.svh"
module pipe_domain_position_projector_top
    import pdp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  pdp_in_t in_data,
    output logic out_valid,
    output pdp_out_t out_data,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    localparam int W = 36;
    localparam int SqW = 72;
    localparam int NumW = 66;
    // Tag: x, y, cx, cy (each W), sign_x, sign_y, region(2), do_proj, centre, leg_moved.
    localparam int TagW = 4 * W + 7;

    logic [RegWidth-1:0] rr;
    logic [RegWidth-1:0] hh;

    pdp_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .radius(rr), .leg_height(hh)
    );

    assign busy = 1'b0;

    // Stage 1: region decision and offsets.
    logic s1_vld_reg;
    logic signed [W-1:0] s1_x_reg, s1_y_reg, s1_cx_reg, s1_cy_reg;
    logic signed [W-1:0] s1_dx_reg, s1_dy_reg;
    region_t s1_reg_reg;
    logic signed [W-1:0] s1_nx_reg;
    logic [W-1:0] s1_rad_in_reg, s1_rad_out_reg;
    logic s1_lmov_reg;

    logic signed [W-1:0] xw, yw, rw, hw, r3w;
    logic lower, top;
    logic signed [W-1:0] legx;
    assign xw = W'(in_data.pos_x);
    assign yw = W'(in_data.pos_y);
    assign rw = W'(rr);
    assign hw = W'(hh);
    assign r3w = rw + (rw <<< 1);
    assign lower = (yw < rw) && (xw < r3w);
    assign top = yw > (rw + hw);

    always_comb
    begin
        legx = xw;
        if (xw < r3w)
        begin
            if (xw < 0)
                legx = '0;
            if (xw > (rw <<< 1))
                legx = rw <<< 1;
        end
        else
        begin
            if (xw < (rw <<< 2))
                legx = rw <<< 2;
            if (xw > ((rw <<< 2) + (rw <<< 1)))
                legx = (rw <<< 2) + (rw <<< 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg <= xw;
        s1_y_reg <= yw;
        s1_nx_reg <= legx;
        s1_rad_in_reg <= rw;
        s1_rad_out_reg <= r3w;
        s1_lmov_reg <= !lower && !top && (legx != xw);
        if (lower)
        begin
            s1_reg_reg <= REGION_LOWER;
            s1_cx_reg <= rw;
            s1_cy_reg <= rw;
            s1_dx_reg <= xw - rw;
            s1_dy_reg <= yw - rw;
        end
        else if (top)
        begin
            s1_reg_reg <= REGION_TOP;
            s1_cx_reg <= r3w;
            s1_cy_reg <= rw + hw;
            s1_dx_reg <= xw - r3w;
            s1_dy_reg <= yw - (rw + hw);
        end
        else
        begin
            s1_reg_reg <= REGION_LEGS;
            s1_cx_reg <= '0;
            s1_cy_reg <= '0;
            s1_dx_reg <= '0;
            s1_dy_reg <= '0;
        end
    end

    // Stage 2: squares of magnitudes.
    logic s2_vld_reg;
    logic [SqW-1:0] s2_dx2_reg, s2_dy2_reg, s2_ri2_reg, s2_ro2_reg;
    logic [W-1:0] s2_mx_reg, s2_my_reg;
    logic [W-1:0] mx, my;
    logic s2_sx_reg, s2_sy_reg, s2_zero_reg, s2_lmov_reg;
    logic signed [W-1:0] s2_x_reg, s2_y_reg, s2_cx_reg, s2_cy_reg, s2_nx_reg;
    region_t s2_reg_reg;
    logic [W-1:0] s2_rad_in_reg, s2_rad_out_reg;
    assign mx = s1_dx_reg[W-1] ? W'(-s1_dx_reg) : W'(s1_dx_reg);
    assign my = s1_dy_reg[W-1] ? W'(-s1_dy_reg) : W'(s1_dy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_dx2_reg <= SqW'(mx[31:0]) * SqW'(mx[31:0]);
        s2_dy2_reg <= SqW'(my[31:0]) * SqW'(my[31:0]);
        s2_ri2_reg <= SqW'(s1_rad_in_reg[RegWidth-1:0]) * SqW'(s1_rad_in_reg[RegWidth-1:0]);
        s2_ro2_reg <= SqW'(s1_rad_out_reg[RegWidth+1:0]) * SqW'(s1_rad_out_reg[RegWidth+1:0]);
        s2_mx_reg <= mx;
        s2_my_reg <= my;
        s2_sx_reg <= s1_dx_reg[W-1];
        s2_sy_reg <= s1_dy_reg[W-1];
        s2_zero_reg <= (s1_dx_reg == '0) && (s1_dy_reg == '0);
        s2_lmov_reg <= s1_lmov_reg;
        s2_x_reg <= s1_x_reg;
        s2_y_reg <= s1_y_reg;
        s2_cx_reg <= s1_cx_reg;
        s2_cy_reg <= s1_cy_reg;
        s2_nx_reg <= s1_nx_reg;
        s2_reg_reg <= s1_reg_reg;
        s2_rad_in_reg <= s1_rad_in_reg;
        s2_rad_out_reg <= s1_rad_out_reg;
    end

    // Stage 3: distance compare and projection radius.
    logic s3_vld_reg;
    logic [SqW-1:0] s3_d2_reg;
    logic [W-1:0] s3_rad_reg, s3_mx_reg, s3_my_reg;
    logic [TagW-1:0] s3_tag_reg;
    logic [SqW-1:0] d2;
    logic proj, centre;
    logic [W-1:0] rad;
    assign d2 = s2_dx2_reg + s2_dy2_reg;

    always_comb
    begin
        proj = 1'b0;
        centre = 1'b0;
        rad = s2_rad_in_reg;
        case (s2_reg_reg)
            REGION_LOWER:
                proj = d2 > s2_ri2_reg;
            REGION_TOP:
            begin
                if (s2_zero_reg)
                    centre = 1'b1;
                else if (d2 < s2_ri2_reg)
                    proj = 1'b1;
                else if (d2 > s2_ro2_reg)
                begin
                    proj = 1'b1;
                    rad = s2_rad_out_reg;
                end
            end
            default:
                proj = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_d2_reg <= d2;
        s3_rad_reg <= rad;
        s3_mx_reg <= s2_mx_reg;
        s3_my_reg <= s2_my_reg;
        s3_tag_reg <= {(s2_reg_reg == REGION_LEGS) ? s2_nx_reg : s2_x_reg, s2_y_reg,
                       s2_cx_reg, s2_cy_reg, s2_sx_reg, s2_sy_reg,
                       2'(s2_reg_reg), proj, centre, s2_lmov_reg};
    end

    // Square root; magnitudes and radius travel in the tag.
    localparam int SqTagW = TagW + 3 * W;
    logic sq_vld;
    logic [W-1:0] sq_root;
    logic [SqW-1:0] sq_val;
    logic [SqTagW-1:0] sq_tag;

    pdp_isqrt #(.InWidth(SqW), .OutWidth(W), .TagWidth(SqTagW)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .in_valid(s3_vld_reg), .in_value(s3_d2_reg),
        .in_tag({s3_tag_reg, s3_mx_reg, s3_my_reg, s3_rad_reg}),
        .out_valid(sq_vld), .out_root(sq_root), .out_value(sq_val), .out_tag(sq_tag)
    );

    // Stage 4: numerators |d| * R + floor(L/2).
    logic s4_vld_reg;
    logic [NumW-1:0] s4_nx_reg, s4_ny_reg;
    logic [W-1:0] s4_len_reg;
    logic [TagW-1:0] s4_tag_reg;
    logic [W-1:0] sq_mx, sq_my, sq_rad;
    assign sq_mx = sq_tag[3*W-1:2*W];
    assign sq_my = sq_tag[2*W-1:W];
    assign sq_rad = sq_tag[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else
            s4_vld_reg <= sq_vld && sq_val[0] | sq_vld;
    end

    always_ff @(posedge clk)
    begin
        s4_nx_reg <= NumW'(sq_mx[31:0]) * NumW'(sq_rad[RegWidth+1:0]) + NumW'(sq_root >> 1);
        s4_ny_reg <= NumW'(sq_my[31:0]) * NumW'(sq_rad[RegWidth+1:0]) + NumW'(sq_root >> 1);
        s4_len_reg <= (sq_root == '0) ? W'(1) : sq_root;
        s4_tag_reg <= sq_tag[SqTagW-1:3*W];
    end

    logic dx_vld, dy_vld;
    logic [NumW-1:0] qx, qy;
    logic [TagW-1:0] dx_tag;
    logic dy_sy;

    pdp_div #(.NumWidth(NumW), .DenWidth(W), .TagWidth(TagW)) u_div_x (
        .clk(clk), .rst_n(rst_n), .in_valid(s4_vld_reg), .in_num(s4_nx_reg),
        .in_den(s4_len_reg), .in_tag(s4_tag_reg),
        .out_valid(dx_vld), .out_quot(qx), .out_tag(dx_tag)
    );

    // The y lane carries its own sign bit.
    pdp_div #(.NumWidth(NumW), .DenWidth(W), .TagWidth(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .in_valid(s4_vld_reg), .in_num(s4_ny_reg),
        .in_den(s4_len_reg), .in_tag(s4_tag_reg[5]),
        .out_valid(dy_vld), .out_quot(qy), .out_tag(dy_sy)
    );

    // Stage 5: form coordinates.
    logic signed [W-1:0] tx, ty, tcx, tcy;
    logic tsx, tsy, tproj, tcen, tlmov;
    logic [1:0] treg;
    assign {tx, ty, tcx, tcy, tsx, tsy, treg, tproj, tcen, tlmov} = dx_tag;

    logic signed [W+1:0] fx, fy;
    logic signed [W+1:0] qxs, qys;
    assign qxs = (W+2)'(signed'({1'b0, qx[W-1:0]}));
    assign qys = (W+2)'(signed'({1'b0, qy[W-1:0]}));

    always_comb
    begin
        fx = (W+2)'(tx);
        fy = (W+2)'(ty);
        if (tproj)
        begin
            fx = (W+2)'(tcx) + (tsx ? -qxs : qxs);
            fy = (W+2)'(tcy) + (dy_sy ? -qys : qys);
        end
    end

    logic s5_vld_reg;
    logic signed [W+1:0] s5_fx_reg, s5_fy_reg;
    logic signed [W-1:0] s5_x_reg, s5_y_reg;
    logic [1:0] s5_reg_reg;
    logic s5_cen_reg;
    logic s5_lmov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else
            s5_vld_reg <= dx_vld && dy_vld;
    end

    always_ff @(posedge clk)
    begin
        s5_fx_reg <= fx;
        s5_fy_reg <= fy;
        s5_x_reg <= tx;
        s5_y_reg <= ty;
        s5_reg_reg <= treg;
        s5_cen_reg <= tcen;
        s5_lmov_reg <= tlmov;
    end

    // Stage 6: saturation and output register.
    localparam logic signed [W+1:0] MaxV = (W+2)'((64'sd1 <<< (CoordWidth - 1)) - 1);
    localparam logic signed [W+1:0] MinV = -MaxV - 1;
    logic signed [CoordWidth-1:0] ox, oy;
    always_comb
    begin
        if (s5_fx_reg > MaxV)
            ox = CoordWidth'(MaxV);
        else if (s5_fx_reg < MinV)
            ox = CoordWidth'(MinV);
        else
            ox = CoordWidth'(s5_fx_reg);
        if (s5_fy_reg > MaxV)
            oy = CoordWidth'(MaxV);
        else if (s5_fy_reg < MinV)
            oy = CoordWidth'(MinV);
        else
            oy = CoordWidth'(s5_fy_reg);
    end

    logic out_vld_reg;
    pdp_out_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= s5_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        out_reg.new_x <= ox;
        out_reg.new_y <= oy;
        out_reg.region_code <= s5_reg_reg;
        out_reg.was_moved <= s5_lmov_reg || (ox != CoordWidth'(s5_x_reg)) ||
                             (oy != CoordWidth'(s5_y_reg));
        out_reg.at_centre_flag <= s5_cen_reg;
    end

    assign out_valid = out_vld_reg;
    assign out_data = out_reg;

    `PDP_ASSERT_IMPL(a_lanes_aligned, clk, rst_n, dx_vld, dy_vld)
    `PDP_ASSERT_IMPL(a_lane_sign, clk, rst_n, dx_vld, dy_sy == tsy)
    `PDP_ASSERT_NEXT(a_out_follows, clk, rst_n, s5_vld_reg, out_valid)
    `PDP_ASSERT_IMPL(a_centre_unmoved, clk, rst_n, out_valid && out_data.at_centre_flag,
        !out_data.was_moved)
endmodule

// ----- tb/tb_pipe_domain_position_projector_top.sv -----
module tb_pipe_domain_position_projector_top;
    import pdp_pkg::*;

    localparam int RegMask = (1 << RegWidth) - 1;
    localparam int IdleLimit = 4000;
    localparam int SettleCycles = 8;
    localparam int TailCycles = 300;

    typedef enum logic [1:0] {
        OP_POINT,
        OP_WRITE,
        OP_DRAIN
    } op_kind_t;

    typedef struct {
        op_kind_t kind;
        int unsigned gap;
        logic [0:0] index;
        logic [31:0] value;
        pdp_in_t point;
    } op_t;

    typedef enum logic [2:0] {
        DRV_FETCH,
        DRV_GAP,
        DRV_SEND,
        DRV_DRAIN,
        DRV_SETUP,
        DRV_ACCESS,
        DRV_DONE
    } drv_state_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    pdp_in_t in_data;
    logic out_valid;
    pdp_out_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    op_t pending_ops[$];
    pdp_out_t expected_positions[$];
    op_t cur_op;
    drv_state_t drv_state;
    int unsigned gap_cnt;
    int unsigned settle_cnt;
    int unsigned idle_cycles;
    longint model_radius;
    longint model_height;
    int errors;
    bit no_gaps;

    pipe_domain_position_projector_top u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_data(out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] floor_root(logic [127:0] v);
        logic [63:0] res;
        logic [63:0] t;
        res = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = res | (64'd1 << b);
            if ((128'(t) * 128'(t)) <= v)
            begin
                res = t;
            end
        end
        return res;
    endfunction

    function automatic logic [127:0] magnitude(longint d);
        return d < 0 ? 128'(-d) : 128'(d);
    endfunction

    function automatic longint scale_offset(longint d, logic [63:0] rad, logic [63:0] len);
        logic [127:0] num;
        logic [127:0] q;
        num = magnitude(d) * 128'(rad) + 128'(len >> 1);
        q = num / 128'(len);
        return d < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic [31:0] clamp_coord(longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic pdp_out_t project_position(pdp_in_t p, longint r, longint h);
        longint x;
        longint y;
        longint nx;
        longint ny;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        logic [127:0] d2;
        logic [63:0] rad;
        logic [63:0] len;
        bit proj;
        pdp_out_t o;
        x = longint'(p.pos_x);
        y = longint'(p.pos_y);
        nx = x;
        ny = y;
        o = '0;
        proj = 0;
        rad = '0;
        if (y < r && x < 3 * r)
        begin
            cx = r;
            cy = r;
            o.region_code = REGION_LOWER;
            dx = x - cx;
            dy = y - cy;
            d2 = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy);
            if (d2 > 128'(r) * 128'(r))
            begin
                rad = r;
                proj = 1;
            end
        end
        else if (y > r + h)
        begin
            cx = 3 * r;
            cy = r + h;
            o.region_code = REGION_TOP;
            dx = x - cx;
            dy = y - cy;
            d2 = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy);
            if (dx == 0 && dy == 0)
            begin
                o.at_centre_flag = 1'b1;
            end
            else if (d2 < 128'(r) * 128'(r))
            begin
                rad = r;
                proj = 1;
            end
            else if (d2 > 128'(3 * r) * 128'(3 * r))
            begin
                rad = 3 * r;
                proj = 1;
            end
        end
        else
        begin
            cx = 0;
            cy = 0;
            o.region_code = REGION_LEGS;
            if (x < 3 * r)
            begin
                if (x < 0)
                begin
                    nx = 0;
                end
                if (x > 2 * r)
                begin
                    nx = 2 * r;
                end
            end
            else
            begin
                if (x < 4 * r)
                begin
                    nx = 4 * r;
                end
                if (x > 6 * r)
                begin
                    nx = 6 * r;
                end
            end
        end
        if (proj)
        begin
            len = floor_root(d2);
            nx = cx + scale_offset(dx, rad, len);
            ny = cy + scale_offset(dy, rad, len);
        end
        o.new_x = clamp_coord(nx);
        o.new_y = clamp_coord(ny);
        o.was_moved = (o.new_x != p.pos_x) || (o.new_y != p.pos_y);
        return o;
    endfunction

    task automatic launch_next();
        op_t op;
        if (pending_ops.size() == 0)
        begin
            start <= 1'b0;
            drv_state <= DRV_DONE;
        end
        else
        begin
            op = pending_ops.pop_front();
            cur_op <= op;
            if (op.kind == OP_POINT && op.gap == 0)
            begin
                start <= 1'b1;
                in_data <= op.point;
                drv_state <= DRV_SEND;
            end
            else if (op.kind == OP_POINT)
            begin
                start <= 1'b0;
                gap_cnt <= op.gap - 1;
                drv_state <= DRV_GAP;
            end
            else
            begin
                start <= 1'b0;
                settle_cnt <= 0;
                drv_state <= DRV_DRAIN;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            in_data <= '0;
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= '0;
            pwdata <= '0;
            gap_cnt <= 0;
            settle_cnt <= 0;
            model_radius <= 131072;
            model_height <= 196608;
            drv_state <= DRV_FETCH;
        end
        else
        begin
            case (drv_state)
                DRV_FETCH:
                begin
                    launch_next();
                end
                DRV_GAP:
                begin
                    if (gap_cnt == 0)
                    begin
                        start <= 1'b1;
                        in_data <= cur_op.point;
                        drv_state <= DRV_SEND;
                    end
                    else
                    begin
                        gap_cnt <= gap_cnt - 1;
                    end
                end
                DRV_SEND:
                begin
                    if (!busy)
                    begin
                        expected_positions.push_back(
                            project_position(in_data, model_radius, model_height));
                        launch_next();
                    end
                end
                DRV_DRAIN:
                begin
                    if (expected_positions.size() == 0)
                    begin
                        if (settle_cnt < SettleCycles)
                        begin
                            settle_cnt <= settle_cnt + 1;
                        end
                        else if (cur_op.kind == OP_WRITE)
                        begin
                            psel <= 1'b1;
                            pwrite <= 1'b1;
                            paddr <= {cur_op.index, 2'b00};
                            pwdata <= cur_op.value;
                            drv_state <= DRV_SETUP;
                        end
                        else
                        begin
                            launch_next();
                        end
                    end
                end
                DRV_SETUP:
                begin
                    penable <= 1'b1;
                    drv_state <= DRV_ACCESS;
                end
                DRV_ACCESS:
                begin
                    if (pready)
                    begin
                        if (paddr[2] == ADDR_RADIUS)
                        begin
                            model_radius <= longint'(pwdata & RegMask);
                        end
                        else
                        begin
                            model_height <= longint'(pwdata & RegMask);
                        end
                        psel <= 1'b0;
                        penable <= 1'b0;
                        pwrite <= 1'b0;
                        launch_next();
                    end
                end
                default:
                begin
                    start <= 1'b0;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        pdp_out_t exp_out;
        if (rst_n && out_valid)
        begin
            if (expected_positions.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
                errors++;
            end
            else
            begin
                exp_out = expected_positions.pop_front();
                if (out_data.new_x !== exp_out.new_x)
                begin
                    $display("%0t: new_x expected %0d actual %0d",
                             $time, exp_out.new_x, out_data.new_x);
                    errors++;
                end
                if (out_data.new_y !== exp_out.new_y)
                begin
                    $display("%0t: new_y expected %0d actual %0d",
                             $time, exp_out.new_y, out_data.new_y);
                    errors++;
                end
                if (out_data.region_code !== exp_out.region_code)
                begin
                    $display("%0t: region_code expected %0d actual %0d",
                             $time, exp_out.region_code, out_data.region_code);
                    errors++;
                end
                if (out_data.was_moved !== exp_out.was_moved)
                begin
                    $display("%0t: was_moved expected %0d actual %0d",
                             $time, exp_out.was_moved, out_data.was_moved);
                    errors++;
                end
                if (out_data.at_centre_flag !== exp_out.at_centre_flag)
                begin
                    $display("%0t: at_centre_flag expected %0d actual %0d",
                             $time, exp_out.at_centre_flag, out_data.at_centre_flag);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || out_valid || (start && !busy) || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IdleLimit)
        begin
            $display("pipe_domain_position_projector_top test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_point(longint x, longint y);
        op_t op;
        op.kind = OP_POINT;
        op.gap = no_gaps ? 0 : $urandom_range(0, 3);
        op.index = '0;
        op.value = '0;
        op.point.pos_x = clamp_coord(x);
        op.point.pos_y = clamp_coord(y);
        pending_ops.push_back(op);
    endtask

    task automatic add_raw_point(logic [31:0] x, logic [31:0] y);
        add_point(longint'(signed'(x)), longint'(signed'(y)));
    endtask

    task automatic add_write(logic [0:0] index, logic [31:0] value);
        op_t op;
        op.kind = OP_WRITE;
        op.gap = 0;
        op.index = index;
        op.value = value;
        op.point = '0;
        pending_ops.push_back(op);
    endtask

    task automatic add_drain();
        op_t op;
        op.kind = OP_DRAIN;
        op.gap = 0;
        op.index = '0;
        op.value = '0;
        op.point = '0;
        pending_ops.push_back(op);
    endtask

    task automatic add_random_points(int count, longint r, longint h);
        longint span_x;
        longint span_y;
        longint x;
        longint y;
        span_x = 8 * r + 2;
        span_y = 6 * r + h + 2;
        if (span_x > 64'd4294967295)
        begin
            span_x = 64'd4294967295;
        end
        if (span_y > 64'd4294967295)
        begin
            span_y = 64'd4294967295;
        end
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                add_raw_point($urandom, $urandom);
            end
            else
            begin
                x = -r + longint'($urandom_range(0, 32'(span_x)));
                y = -r + longint'($urandom_range(0, 32'(span_y)));
                add_point(x, y);
            end
        end
    endtask

    initial
    begin
        longint r;
        longint h;
        clk = 1'b0;
        rst_n = 1'b0;
        errors = 0;
        idle_cycles = 0;
        no_gaps = 0;

        r = 131072;
        h = 196608;
        add_raw_point(32'h7fffffff, 32'h7fffffff);
        add_raw_point(32'h80000000, 32'h80000000);
        add_raw_point(32'h7fffffff, 32'h80000000);
        add_raw_point(32'h80000000, 32'h7fffffff);
        add_raw_point(32'h0, 32'h0);
        add_raw_point(32'hffffffff, 32'haaaaaaaa);
        add_raw_point(32'h55555555, 32'hffffffff);
        add_point(r, r);
        add_point(3 * r, r + h);
        add_point(3 * r, r + h + 1);
        add_point(3 * r + 1, r + h + 1);
        add_point(3 * r, r + h + 3 * r + 5);
        add_point(-5, r + 1);
        add_point(2 * r + 7, r + 1);
        add_point(4 * r - 3, r + h);
        add_point(6 * r + 9, r);
        add_point(2 * r, 0);
        add_point(3 * r - 1, -r);
        add_point(0, r - 1);
        add_point(3 * r, r - 1);
        add_random_points(250, r, h);

        add_write(ADDR_RADIUS, 32'd1);
        add_write(ADDR_LEG_HEIGHT, 32'd0);
        add_point(1, 1);
        add_point(3, 1);
        add_point(3, 2);
        add_random_points(250, 1, 0);

        add_write(ADDR_RADIUS, 32'hffffffff);
        add_write(ADDR_LEG_HEIGHT, 32'hffffffff);
        r = RegMask;
        h = RegMask;
        add_point(3 * r, r + h + 1);
        add_point(6 * r, 2 * r);
        add_random_points(150, r, h);
        add_drain();
        add_random_points(150, r, h);

        add_write(ADDR_RADIUS, 32'd0);
        add_write(ADDR_LEG_HEIGHT, 32'd65536);
        add_point(0, 0);
        add_point(0, 65537);
        add_random_points(100, 8, 65536);

        no_gaps = 1;
        r = $urandom_range(1, 1 << 20);
        h = $urandom_range(0, 1 << 22);
        add_write(ADDR_RADIUS, 32'(r));
        add_write(ADDR_LEG_HEIGHT, 32'(h));
        add_random_points(300, r, h);
        no_gaps = 0;

        r = $urandom_range(1, RegMask);
        h = $urandom_range(0, RegMask);
        add_write(ADDR_RADIUS, 32'(r) | 32'hf0000000);
        add_write(ADDR_LEG_HEIGHT, 32'(h));
        add_random_points(300, r, h);

        r = $urandom_range(1, 1 << 16);
        h = $urandom_range(0, 1 << 16);
        add_write(ADDR_RADIUS, 32'(r));
        add_write(ADDR_LEG_HEIGHT, 32'(h));
        add_random_points(300, r, h);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (drv_state == DRV_DONE && expected_positions.size() == 0);
        repeat (TailCycles) @(posedge clk);
        if (errors == 0 && expected_positions.size() == 0)
        begin
            $display("pipe_domain_position_projector_top test passed");
        end
        else
        begin
            $display("pipe_domain_position_projector_top test failed");
        end
        $finish;
    end
endmodule
